// ===== src/sdc_pkg.sv =====
// -----------------------------------------------------------------------------
// sdc_pkg
// Types and fixed constants shared by the stereo delay / chorus block and its
// checker: word formats, register indexes, gains and saturation helpers.
// -----------------------------------------------------------------------------
package sdc_pkg;

   localparam int SAMPLE_BITS = 24;
   localparam int PHASE_BITS  = 24;
   localparam int VOICE_COUNT = 3;
   localparam int VOICE_W     = 2;

   // shared multiplier operand width, product is twice this
   localparam int MUL_W = 29;

   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 24;

   // chorus coefficient 0.505 + 0.495 * lfo in Q.22
   localparam int COEF_BASE  = 2118124;
   localparam int COEF_SWING = 2076180;

   // voice sum scale: floor((sum * send + 3 * 2^15) / (3 * 2^16))
   localparam int SCALE_HALF  = 98304;
   localparam int DIV3_MAGIC  = 178956971;
   localparam int DIV3_SHIFT  = 29;
   localparam int DIV3_BIAS_Q = 33554432;
   localparam int DIV3_BIAS_U = 100663296;

   localparam logic [16:0] PAN_LEFT  [VOICE_COUNT] = '{17'd65536, 17'd56755, 17'd32768};
   localparam logic [16:0] PAN_RIGHT [VOICE_COUNT] = '{17'd0, 17'd32768, 17'd56755};

   // three-phase lfo start: 1.0, -0.5, -0.5 in Q2.22
   localparam logic signed [PHASE_BITS-1:0] PHASE_INIT [VOICE_COUNT] =
      '{24'sd4194304, -24'sd2097152, -24'sd2097152};

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_DELAY_LENGTH = 3'd0,
      CSR_DELAY_SEND   = 3'd1,
      CSR_DELAY_CROSS  = 3'd2,
      CSR_CHORUS_DEPTH = 3'd3,
      CSR_LFO_STEP     = 3'd4,
      CSR_CHORUS_SEND  = 3'd5
   } csr_index_type;

   typedef struct packed {
      logic signed [SAMPLE_BITS-1:0] left_in;
      logic signed [SAMPLE_BITS-1:0] right_in;
   } req_type;

   typedef struct packed {
      logic signed [SAMPLE_BITS-1:0] left_out;
      logic signed [SAMPLE_BITS-1:0] right_out;
   } rsp_type;

   function automatic logic signed [SAMPLE_BITS-1:0] sat_sample(input logic signed [31:0] v);
      logic signed [31:0] hi;
      logic signed [31:0] lo;
      hi = (32'sd1 <<< (SAMPLE_BITS - 1)) - 32'sd1;
      lo = -(32'sd1 <<< (SAMPLE_BITS - 1));
      if (v > hi) begin
         return SAMPLE_BITS'(hi);
      end else if (v < lo) begin
         return SAMPLE_BITS'(lo);
      end
      return SAMPLE_BITS'(v);
   endfunction

   function automatic logic signed [PHASE_BITS-1:0] sat_phase(input logic signed [31:0] v);
      logic signed [31:0] hi;
      logic signed [31:0] lo;
      hi = (32'sd1 <<< (PHASE_BITS - 1)) - 32'sd1;
      lo = -(32'sd1 <<< (PHASE_BITS - 1));
      if (v > hi) begin
         return PHASE_BITS'(hi);
      end else if (v < lo) begin
         return PHASE_BITS'(lo);
      end
      return PHASE_BITS'(v);
   endfunction

endpackage

// ===== src/stereo_delay_chorus_effect.sv =====
// -----------------------------------------------------------------------------
// stereo_delay_chorus_effect
// Stereo feedback delay with a three-voice lfo chorus. Both delay rings share
// one RAM (left and right side by side); one shared multiplier does all math.
// -----------------------------------------------------------------------------
//   channel | direction | handshake           | word
//   req_    | in        | req_valid/req_stall | left_in, right_in (Q1.23)
//   rsp_    | out       | rsp_valid/rsp_stall | left_out, right_out (Q1.23)
//   csr_    | in        | csr_valid/csr_ready | csr_index, csr_data
//
// A new word is taken only once the result of the last one has been loaded into
// the output register; the pace is set by the single RAM read port (seven ring reads per
// word) and the shared multiplier (29 products).
// After reset a clearing pass writes zero to all RING_DEPTH ring entries, one a
// cycle; req_stall stays high during it. A result waits in the output register
// while rsp_stall is high; the next word may be accepted meanwhile.
// -----------------------------------------------------------------------------
module stereo_delay_chorus_effect #(
   parameter int RING_DEPTH = 65536   // power of two
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_valid,
   output logic                             req_stall,
   input  sdc_pkg::req_type                 req_data,
   output logic                             rsp_valid,
   input  logic                             rsp_stall,
   output sdc_pkg::rsp_type                 rsp_data,
   input  logic                             csr_valid,
   output logic                             csr_ready,
   input  logic [sdc_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [sdc_pkg::CSR_DATA_W-1:0]   csr_data
);

   localparam int SW  = sdc_pkg::SAMPLE_BITS;
   localparam int PHW = sdc_pkg::PHASE_BITS;
   localparam int MW  = sdc_pkg::MUL_W;
   localparam int PRW = 2 * MW;
   localparam int AW  = $clog2(RING_DEPTH);
   localparam int PW  = AW + 16;
   localparam int DW  = SW + 1;
   localparam int CW  = SW + 3;
   localparam int RW  = 2 * SW;

   typedef enum logic [31:0] {
      ST_CLEAR  = 32'd1 << 0,
      ST_IDLE   = 32'd1 << 1,
      ST_D_RD   = 32'd1 << 2,
      ST_D_SL   = 32'd1 << 3,
      ST_D_SR   = 32'd1 << 4,
      ST_D_SD   = 32'd1 << 5,
      ST_D_XL   = 32'd1 << 6,
      ST_D_XR   = 32'd1 << 7,
      ST_D_WB   = 32'd1 << 8,
      ST_V_PH   = 32'd1 << 9,
      ST_V_COEF = 32'd1 << 10,
      ST_V_OFF  = 32'd1 << 11,
      ST_V_POS  = 32'd1 << 12,
      ST_V_RDP  = 32'd1 << 13,
      ST_V_RDC  = 32'd1 << 14,
      ST_V_IL   = 32'd1 << 15,
      ST_V_IR   = 32'd1 << 16,
      ST_V_PL   = 32'd1 << 17,
      ST_V_PR   = 32'd1 << 18,
      ST_V_ACC  = 32'd1 << 19,
      ST_L_0    = 32'd1 << 20,
      ST_L_0B   = 32'd1 << 21,
      ST_L_1    = 32'd1 << 22,
      ST_L_1B   = 32'd1 << 23,
      ST_L_2    = 32'd1 << 24,
      ST_L_2B   = 32'd1 << 25,
      ST_C_SL   = 32'd1 << 26,
      ST_C_SR   = 32'd1 << 27,
      ST_C_DL   = 32'd1 << 28,
      ST_C_DR   = 32'd1 << 29,
      ST_C_FIN  = 32'd1 << 30,
      ST_OUT    = 32'd1 << 31
   } state_type;

   state_type state_ff, state_in;

   // configuration
   logic [15:0] cfg_length_ff;
   logic [15:0] cfg_dsend_ff;
   logic [15:0] cfg_cross_ff;
   logic [22:0] cfg_depth_ff;
   logic [23:0] cfg_step_ff;
   logic [15:0] cfg_csend_ff;

   // control
   logic [AW-1:0]                 clr_cnt_ff;
   logic [AW-1:0]                 wp_ff;
   logic [sdc_pkg::VOICE_W-1:0]   voice_ff;
   logic                          rsp_valid_ff;
   logic                          out_load;

   // datapath
   sdc_pkg::req_type              x_ff;
   sdc_pkg::rsp_type              rsp_data_ff;
   logic signed [PHW-1:0]         phase_ff [sdc_pkg::VOICE_COUNT];
   logic signed [DW-1:0]          dl_ff, dr_ff;
   logic signed [SW-1:0]          wl_ff, wr_ff;
   logic signed [DW-1:0]          coef_ff;
   logic [AW-1:0]                 cur_ff;
   logic [15:0]                   frac_ff;
   logic signed [SW-1:0]          pre_l_ff, pre_r_ff;
   logic signed [SW-1:0]          il_ff, ir_ff;
   logic signed [CW-1:0]          cl_ff, cr_ff;
   logic signed [CW:0]            ql_ff, qr_ff;
   logic signed [PRW-1:0]         prod_ff;
   logic signed [MW-1:0]          mul_a, mul_b;

   // ring memory
   logic                          ram_wr_en;
   logic [AW-1:0]                 ram_wr_addr;
   logic [RW-1:0]                 ram_wr_data;
   logic                          ram_rd_en;
   logic [AW-1:0]                 ram_rd_addr;
   logic [RW-1:0]                 ram_rd_data;

   logic signed [SW-1:0]          tap_l, tap_r;
   logic signed [PRW-1:0]         rnd14, rnd16, rnd22, rnd24, scaled, div_q;
   logic signed [31:0]            wl_sum, wr_sum;
   logic signed [SW-1:0]          wr_sat;
   logic [PW-1:0]                 pos;

   sdc_ram #(
      .WIDTH (RW),
      .DEPTH (RING_DEPTH)
   ) u_ring (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_en   (ram_rd_en),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   assign tap_l = $signed(ram_rd_data[RW-1:SW]);
   assign tap_r = $signed(ram_rd_data[SW-1:0]);

   // round half up of the last product, plus the voice sum scale and divide by three
   assign rnd14  = (prod_ff + PRW'(8192)) >>> 14;
   assign rnd16  = (prod_ff + PRW'(32768)) >>> 16;
   assign rnd22  = (prod_ff + PRW'(2097152)) >>> 22;
   assign rnd24  = (prod_ff + PRW'(8388608)) >>> 24;
   assign scaled = (prod_ff + PRW'(sdc_pkg::SCALE_HALF)) >>> 16;
   assign div_q  = (prod_ff >>> sdc_pkg::DIV3_SHIFT) - PRW'(sdc_pkg::DIV3_BIAS_Q);

   // input plus own tap plus crossfeed correction: x + dl + round((dr - dl) * cross)
   assign wl_sum = 32'(x_ff.left_in) + 32'(dl_ff) + 32'(rnd16);
   assign wr_sum = 32'(x_ff.right_in) + 32'(dr_ff) + 32'(rnd16);
   assign wr_sat = sdc_pkg::sat_sample(wr_sum);

   // chorus read position in Q.16, wraps around the ring
   assign pos = {wp_ff, 16'd0} - PW'(rnd14);

   // ring access
   always_comb begin
      ram_wr_en   = 1'b0;
      ram_wr_addr = wp_ff;
      ram_wr_data = {wl_ff, wr_sat};
      ram_rd_en   = 1'b0;
      ram_rd_addr = cur_ff;
      unique case (state_ff)
         ST_CLEAR: begin
            ram_wr_en   = 1'b1;
            ram_wr_addr = clr_cnt_ff;
            ram_wr_data = '0;
         end
         ST_D_RD: begin
            ram_rd_en   = 1'b1;
            ram_rd_addr = wp_ff - AW'(cfg_length_ff);
         end
         ST_D_WB: begin
            ram_wr_en = 1'b1;
         end
         ST_V_RDP: begin
            ram_rd_en   = 1'b1;
            ram_rd_addr = cur_ff - AW'(1);
         end
         ST_V_RDC: begin
            ram_rd_en = 1'b1;
         end
         default: begin
         end
      endcase
   end

   // shared multiplier operands
   always_comb begin
      mul_a = '0;
      mul_b = '0;
      unique case (state_ff)
         ST_D_SL: begin
            mul_a = MW'(tap_l);
            mul_b = MW'(cfg_dsend_ff);
         end
         ST_D_SR: begin
            mul_a = MW'(tap_r);
            mul_b = MW'(cfg_dsend_ff);
         end
         ST_D_XL: begin
            mul_a = MW'(dr_ff) - MW'(dl_ff);
            mul_b = MW'(cfg_cross_ff);
         end
         ST_D_XR: begin
            mul_a = MW'(dl_ff) - MW'(dr_ff);
            mul_b = MW'(cfg_cross_ff);
         end
         ST_V_PH: begin
            mul_a = MW'(phase_ff[voice_ff]);
            mul_b = MW'(sdc_pkg::COEF_SWING);
         end
         ST_V_OFF: begin
            mul_a = MW'(coef_ff);
            mul_b = MW'(cfg_depth_ff);
         end
         ST_V_IL: begin
            mul_a = MW'(tap_l) - MW'(pre_l_ff);
            mul_b = MW'(frac_ff);
         end
         ST_V_IR: begin
            mul_a = MW'(tap_r) - MW'(pre_r_ff);
            mul_b = MW'(frac_ff);
         end
         ST_V_PL: begin
            mul_a = MW'(il_ff);
            mul_b = MW'(sdc_pkg::PAN_LEFT[voice_ff]);
         end
         ST_V_PR: begin
            mul_a = MW'(ir_ff);
            mul_b = MW'(sdc_pkg::PAN_RIGHT[voice_ff]);
         end
         ST_L_0: begin
            mul_a = MW'(phase_ff[1]) - MW'(phase_ff[2]);
            mul_b = MW'(cfg_step_ff);
         end
         ST_L_1: begin
            mul_a = MW'(phase_ff[2]) - MW'(phase_ff[0]);
            mul_b = MW'(cfg_step_ff);
         end
         ST_L_2: begin
            mul_a = MW'(phase_ff[0]) - MW'(phase_ff[1]);
            mul_b = MW'(cfg_step_ff);
         end
         ST_C_SL: begin
            mul_a = MW'(cl_ff);
            mul_b = MW'(cfg_csend_ff);
         end
         ST_C_SR: begin
            mul_a = MW'(cr_ff);
            mul_b = MW'(cfg_csend_ff);
         end
         ST_C_DL: begin
            mul_a = MW'(ql_ff) + MW'(sdc_pkg::DIV3_BIAS_U);
            mul_b = MW'(sdc_pkg::DIV3_MAGIC);
         end
         ST_C_DR: begin
            mul_a = MW'(qr_ff) + MW'(sdc_pkg::DIV3_BIAS_U);
            mul_b = MW'(sdc_pkg::DIV3_MAGIC);
         end
         default: begin
         end
      endcase
   end

   assign out_load = (state_ff == ST_OUT) && (!rsp_valid_ff || !rsp_stall);

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_CLEAR:  if (clr_cnt_ff == AW'(RING_DEPTH - 1)) state_in = ST_IDLE;
         ST_IDLE:   if (req_valid) state_in = ST_D_RD;
         ST_D_RD:   state_in = ST_D_SL;
         ST_D_SL:   state_in = ST_D_SR;
         ST_D_SR:   state_in = ST_D_SD;
         ST_D_SD:   state_in = ST_D_XL;
         ST_D_XL:   state_in = ST_D_XR;
         ST_D_XR:   state_in = ST_D_WB;
         ST_D_WB:   state_in = ST_V_PH;
         ST_V_PH:   state_in = ST_V_COEF;
         ST_V_COEF: state_in = ST_V_OFF;
         ST_V_OFF:  state_in = ST_V_POS;
         ST_V_POS:  state_in = ST_V_RDP;
         ST_V_RDP:  state_in = ST_V_RDC;
         ST_V_RDC:  state_in = ST_V_IL;
         ST_V_IL:   state_in = ST_V_IR;
         ST_V_IR:   state_in = ST_V_PL;
         ST_V_PL:   state_in = ST_V_PR;
         ST_V_PR:   state_in = ST_V_ACC;
         ST_V_ACC: begin
            if (voice_ff == sdc_pkg::VOICE_W'(sdc_pkg::VOICE_COUNT - 1)) begin
               state_in = ST_L_0;
            end else begin
               state_in = ST_V_PH;
            end
         end
         ST_L_0:    state_in = ST_L_0B;
         ST_L_0B:   state_in = ST_L_1;
         ST_L_1:    state_in = ST_L_1B;
         ST_L_1B:   state_in = ST_L_2;
         ST_L_2:    state_in = ST_L_2B;
         ST_L_2B:   state_in = ST_C_SL;
         ST_C_SL:   state_in = ST_C_SR;
         ST_C_SR:   state_in = ST_C_DL;
         ST_C_DL:   state_in = ST_C_DR;
         ST_C_DR:   state_in = ST_C_FIN;
         ST_C_FIN:  state_in = ST_OUT;
         ST_OUT:    if (out_load) state_in = ST_IDLE;
         default:   state_in = ST_CLEAR;
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         clr_cnt_ff   <= '0;
         wp_ff        <= '0;
         voice_ff     <= '0;
         rsp_valid_ff <= 1'b0;
         phase_ff     <= sdc_pkg::PHASE_INIT;
      end else begin
         state_ff <= state_in;
         if (state_ff == ST_CLEAR) begin
            clr_cnt_ff <= clr_cnt_ff + AW'(1);
         end
         if (state_ff == ST_IDLE && req_valid) begin
            wp_ff <= wp_ff + AW'(1);
         end
         if (state_ff == ST_D_WB) begin
            voice_ff <= '0;
         end else if (state_ff == ST_V_ACC) begin
            voice_ff <= voice_ff + sdc_pkg::VOICE_W'(1);
         end
         // lfo advances one phase at a time, each using the fresh ones
         if (state_ff == ST_L_0B) begin
            phase_ff[0] <= sdc_pkg::sat_phase(32'(phase_ff[0]) + 32'(rnd24));
         end
         if (state_ff == ST_L_1B) begin
            phase_ff[1] <= sdc_pkg::sat_phase(32'(phase_ff[1]) + 32'(rnd24));
         end
         if (state_ff == ST_L_2B) begin
            phase_ff[2] <= sdc_pkg::sat_phase(32'(phase_ff[2]) + 32'(rnd24));
         end
         if (out_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // datapath registers
   always_ff @(posedge clock) begin
      prod_ff <= mul_a * mul_b;
      unique case (state_ff)
         ST_IDLE:   x_ff <= req_data;
         ST_D_SR:   dl_ff <= DW'(rnd16);
         ST_D_SD:   dr_ff <= DW'(rnd16);
         ST_D_XR:   wl_ff <= sdc_pkg::sat_sample(wl_sum);
         ST_D_WB: begin
            wr_ff <= wr_sat;
            cl_ff <= '0;
            cr_ff <= '0;
         end
         ST_V_COEF: coef_ff <= DW'(32'(sdc_pkg::COEF_BASE) + 32'(rnd22));
         ST_V_POS: begin
            cur_ff  <= pos[PW-1:16];
            frac_ff <= pos[15:0];
         end
         ST_V_RDC: begin
            pre_l_ff <= tap_l;
            pre_r_ff <= tap_r;
         end
         ST_V_IR:   il_ff <= SW'(32'(pre_l_ff) + 32'(rnd16));
         ST_V_PL:   ir_ff <= SW'(32'(pre_r_ff) + 32'(rnd16));
         ST_V_PR:   cl_ff <= cl_ff + CW'(rnd16);
         ST_V_ACC:  cr_ff <= cr_ff + CW'(rnd16);
         ST_C_SR:   ql_ff <= $signed(scaled[CW:0]);
         ST_C_DL:   qr_ff <= $signed(scaled[CW:0]);
         ST_C_DR:   cl_ff <= $signed(div_q[CW-1:0]);
         ST_C_FIN:  cr_ff <= $signed(div_q[CW-1:0]);
         default: begin
         end
      endcase
      if (out_load) begin
         rsp_data_ff.left_out  <= sdc_pkg::sat_sample(32'(wl_ff) + 32'(cl_ff));
         rsp_data_ff.right_out <= sdc_pkg::sat_sample(32'(wr_ff) + 32'(cr_ff));
      end
   end

   // configuration writes
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_length_ff <= '0;
         cfg_dsend_ff  <= '0;
         cfg_cross_ff  <= '0;
         cfg_depth_ff  <= '0;
         cfg_step_ff   <= '0;
         cfg_csend_ff  <= '0;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            sdc_pkg::CSR_DELAY_LENGTH: cfg_length_ff <= csr_data[15:0];
            sdc_pkg::CSR_DELAY_SEND:   cfg_dsend_ff  <= csr_data[15:0];
            sdc_pkg::CSR_DELAY_CROSS:  cfg_cross_ff  <= csr_data[15:0];
            sdc_pkg::CSR_CHORUS_DEPTH: cfg_depth_ff  <= csr_data[22:0];
            sdc_pkg::CSR_LFO_STEP:     cfg_step_ff   <= csr_data[23:0];
            sdc_pkg::CSR_CHORUS_SEND:  cfg_csend_ff  <= csr_data[15:0];
            default: begin
            end
         endcase
      end
   end

   assign req_stall = (state_ff != ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;
   assign csr_ready = 1'b1;

endmodule

// ===== src/sdc_ram.sv =====
// -----------------------------------------------------------------------------
// sdc_ram
// Generic simple dual-port RAM: one write port, one read port, read data
// registered (held while no read is issued).
// -----------------------------------------------------------------------------
module sdc_ram #(
   parameter int WIDTH = 48,
   parameter int DEPTH = 65536
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== src/sdc_checker.sv =====
// -----------------------------------------------------------------------------
// sdc_checker
// Port-level checks on the stereo delay / chorus block, bound to the top level.
// -----------------------------------------------------------------------------
module sdc_checker (
   input logic                           clock,
   input logic                           reset,
   input logic                           req_valid,
   input logic                           req_stall,
   input sdc_pkg::req_type               req_data,
   input logic                           rsp_valid,
   input logic                           rsp_stall,
   input sdc_pkg::rsp_type               rsp_data,
   input logic                           csr_valid,
   input logic                           csr_ready,
   input logic [sdc_pkg::CSR_IDX_W-1:0]  csr_index,
   input logic [sdc_pkg::CSR_DATA_W-1:0] csr_data
);

   logic req_take;
   logic csr_take;

   assign req_take = req_valid && !req_stall;
   assign csr_take = csr_valid && csr_ready;

   // a waiting result word holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_data))
      else $error("result word changed while stalled");

   // one word at a time
   a_one_word: assert property (@(posedge clock) disable iff (reset)
      req_take |=> req_stall)
      else $error("input taken again right after a word");

   // a word needs many cycles, no result right behind it
   a_no_early_rsp: assert property (@(posedge clock) disable iff (reset)
      req_take && !rsp_valid |=> !rsp_valid)
      else $error("result appeared right after input");

   // reset empties output and starts the ring clearing pass
   a_reset_state: assert property (@(posedge clock)
      reset |=> !rsp_valid && req_stall)
      else $error("bad state after reset");

   // config port always open
   a_csr_open: assert property (@(posedge clock) disable iff (reset)
      csr_valid && !csr_take |-> 1'b0)
      else $error("config write refused");

endmodule

bind stereo_delay_chorus_effect sdc_checker u_sdc_checker (.*);
